// ===== src/alubs_pkg.sv =====
// Shared types and constants for the ALU with barrel shifter and flags.
`default_nettype none

package alubs_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OP_W    = 4;
  localparam int unsigned AMT_W   = 8;
  localparam int unsigned FLAGS_W = 4;

  // Flag bit positions within an NZCV nibble
  localparam int unsigned FLAG_N = 3;
  localparam int unsigned FLAG_Z = 2;
  localparam int unsigned FLAG_C = 1;
  localparam int unsigned FLAG_V = 0;

  typedef enum logic [OP_W-1:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_t;

  typedef enum logic [1:0] {
    SF_ROT_IMM = 2'd0,
    SF_IMM_SH  = 2'd1,
    SF_REG_SH  = 2'd2
  } shift_form_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_type_t;

  typedef struct packed {
    logic [DATA_W-1:0] op2;
    logic              carry;
  } shift_res_t;

endpackage

`default_nettype wire

// ===== src/alubs_shifter.sv =====
// Barrel shifter: forms the second operand and the shifter carry.
`default_nettype none

module alubs_shifter (
  input  wire logic [alubs_pkg::DATA_W-1:0] operand_b,
  input  wire logic [1:0]                   shift_form,
  input  wire logic [1:0]                   shift_type,
  input  wire logic [alubs_pkg::AMT_W-1:0]  shift_amount,
  input  wire logic                         carry_in,
  output alubs_pkg::shift_res_t             res
);
  import alubs_pkg::*;

  localparam logic [AMT_W-1:0] AMT_FULL = AMT_W'(DATA_W);

  logic [DATA_W-1:0]   imm8;
  logic [4:0]          imm_rot;
  logic [2*DATA_W-1:0] imm_wide;
  logic [DATA_W-1:0]   imm_val;
  logic [AMT_W-1:0]    eff_amt;
  logic [DATA_W:0]     lsl_w;
  logic [DATA_W:0]     lsr_w;
  logic [DATA_W:0]     asr_w;
  logic [2*DATA_W-1:0] ror_wide;
  logic [DATA_W-1:0]   ror_val;
  logic                sign;

  assign imm8     = {{(DATA_W-8){1'b0}}, operand_b[7:0]};
  assign imm_rot  = {shift_amount[3:0], 1'b0};
  assign imm_wide = {imm8, imm8} >> imm_rot;
  assign imm_val  = imm_wide[DATA_W-1:0];

  // Immediate LSR/ASR by zero encode a shift by the full width
  always_comb begin
    if (shift_form_t'(shift_form) == SF_IMM_SH) begin
      if (shift_amount[4:0] == 5'd0 &&
          (shift_type_t'(shift_type) == SH_LSR || shift_type_t'(shift_type) == SH_ASR)) begin
        eff_amt = AMT_FULL;
      end else begin
        eff_amt = {3'b000, shift_amount[4:0]};
      end
    end else begin
      eff_amt = shift_amount;
    end
  end

  // Extra bit below/above the word catches the last bit shifted out
  assign sign     = operand_b[DATA_W-1];
  assign lsl_w    = {1'b0, operand_b} << eff_amt[5:0];
  assign lsr_w    = {operand_b, 1'b0} >> eff_amt[5:0];
  assign asr_w    = (DATA_W+1)'($signed({operand_b, 1'b0}) >>> eff_amt[4:0]);
  assign ror_wide = {operand_b, operand_b} >> eff_amt[4:0];
  assign ror_val  = ror_wide[DATA_W-1:0];

  always_comb begin
    res.op2   = operand_b;
    res.carry = carry_in;
    if (shift_form_t'(shift_form) == SF_ROT_IMM) begin
      res.op2 = imm_val;
      if (imm_rot != 5'd0) begin
        res.carry = imm_val[DATA_W-1];
      end
    end else if (eff_amt != '0) begin
      case (shift_type_t'(shift_type))
        SH_LSL: begin
          if (eff_amt > AMT_FULL) begin
            res.op2   = '0;
            res.carry = 1'b0;
          end else begin
            res.op2   = lsl_w[DATA_W-1:0];
            res.carry = lsl_w[DATA_W];
          end
        end
        SH_LSR: begin
          if (eff_amt > AMT_FULL) begin
            res.op2   = '0;
            res.carry = 1'b0;
          end else begin
            res.op2   = lsr_w[DATA_W:1];
            res.carry = lsr_w[0];
          end
        end
        SH_ASR: begin
          if (eff_amt >= AMT_FULL) begin
            res.op2   = {DATA_W{sign}};
            res.carry = sign;
          end else begin
            res.op2   = asr_w[DATA_W:1];
            res.carry = asr_w[0];
          end
        end
        default: begin
          res.op2   = ror_val;
          res.carry = ror_val[DATA_W-1];
        end
      endcase
    end else if (shift_form_t'(shift_form) == SF_IMM_SH &&
                 shift_type_t'(shift_type) == SH_ROR) begin
      // RRX: one-bit rotate through carry
      res.op2   = {carry_in, operand_b[DATA_W-1:1]};
      res.carry = operand_b[0];
    end
  end

endmodule

`default_nettype wire

// ===== src/alubs_alu.sv =====
// 16-operation ALU with NZCV flag generation.
`default_nettype none

module alubs_alu (
  input  wire logic [alubs_pkg::OP_W-1:0]    action,
  input  wire logic [alubs_pkg::DATA_W-1:0]  operand_a,
  input  wire alubs_pkg::shift_res_t         shifted,
  input  wire logic                          set_flags,
  input  wire logic [alubs_pkg::FLAGS_W-1:0] flags_in,
  output logic [alubs_pkg::DATA_W-1:0]       result,
  output logic                               write_result,
  output logic [alubs_pkg::FLAGS_W-1:0]      flags_out
);
  import alubs_pkg::*;

  logic [DATA_W-1:0] add_x;
  logic [DATA_W-1:0] add_y;
  logic              add_ci;
  logic [DATA_W:0]   sum;
  logic              ovf;
  logic [DATA_W-1:0] res;
  logic              logical;
  logic              c_in;
  logic [DATA_W-1:0] op2;

  assign c_in = flags_in[FLAG_C];
  assign op2  = shifted.op2;

  always_comb begin
    add_x  = operand_a;
    add_y  = op2;
    add_ci = 1'b0;
    case (alu_op_t'(action))
      OP_SUB, OP_CMP: begin
        add_y  = ~op2;
        add_ci = 1'b1;
      end
      OP_RSB: begin
        add_x  = op2;
        add_y  = ~operand_a;
        add_ci = 1'b1;
      end
      OP_ADC: add_ci = c_in;
      OP_SBC: begin
        add_y  = ~op2;
        add_ci = c_in;
      end
      OP_RSC: begin
        add_x  = op2;
        add_y  = ~operand_a;
        add_ci = c_in;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y} + {{DATA_W{1'b0}}, add_ci};
  assign ovf = ~(add_x[DATA_W-1] ^ add_y[DATA_W-1]) & (add_x[DATA_W-1] ^ sum[DATA_W-1]);

  always_comb begin
    logical = 1'b1;
    case (alu_op_t'(action))
      OP_AND, OP_TST: res = operand_a & op2;
      OP_EOR, OP_TEQ: res = operand_a ^ op2;
      OP_ORR:         res = operand_a | op2;
      OP_MOV:         res = op2;
      OP_BIC:         res = operand_a & ~op2;
      OP_MVN:         res = ~op2;
      default: begin
        res     = sum[DATA_W-1:0];
        logical = 1'b0;
      end
    endcase
  end

  always_comb begin
    write_result = !(action inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
    result       = write_result ? res : '0;
    flags_out    = flags_in;
    if (set_flags) begin
      flags_out[FLAG_N] = res[DATA_W-1];
      flags_out[FLAG_Z] = (res == '0);
      if (logical) begin
        flags_out[FLAG_C] = shifted.carry;
      end else begin
        flags_out[FLAG_C] = sum[DATA_W];
        flags_out[FLAG_V] = ovf;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/alu_with_barrel_shifter_and_flags.sv =====
// Data-processing unit: one item per clock through an input register, the barrel
// shifter and ALU, and a result register. out_valid rises once the item has moved from
// the input register into the result register; a new item is taken every cycle while
// the output side keeps up, and the one pass through the shifter and the 32-bit adder
// sets the clock period. in_ready follows out_ready combinationally when both register
// stages hold items.
`default_nettype none

module alu_with_barrel_shifter_and_flags (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [alubs_pkg::OP_W-1:0]      in_action,
  input  wire logic [alubs_pkg::DATA_W-1:0]    in_operand_a,
  input  wire logic [alubs_pkg::DATA_W-1:0]    in_operand_b,
  input  wire logic [1:0]                      in_shift_form,
  input  wire logic [1:0]                      in_shift_type,
  input  wire logic [alubs_pkg::AMT_W-1:0]     in_shift_amount,
  input  wire logic                            in_set_flags,
  input  wire logic [alubs_pkg::FLAGS_W-1:0]   in_flags_in,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [alubs_pkg::DATA_W-1:0]         out_result,
  output logic                                 out_write_result,
  output logic [alubs_pkg::FLAGS_W-1:0]        out_flags_out
);
  import alubs_pkg::*;

  // Input register stage
  logic                s1_valid_r;
  logic [OP_W-1:0]     s1_action_r;
  logic [DATA_W-1:0]   s1_a_r;
  logic [DATA_W-1:0]   s1_b_r;
  logic [1:0]          s1_form_r;
  logic [1:0]          s1_type_r;
  logic [AMT_W-1:0]    s1_amt_r;
  logic                s1_set_r;
  logic [FLAGS_W-1:0]  s1_flags_r;

  // Result register stage
  logic                out_valid_r;
  logic [DATA_W-1:0]   out_result_r;
  logic                out_write_r;
  logic [FLAGS_W-1:0]  out_flags_r;

  logic                s1_adv;
  logic                in_take;
  shift_res_t          shifted;
  logic [DATA_W-1:0]   alu_result;
  logic                alu_write;
  logic [FLAGS_W-1:0]  alu_flags;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_action;
      s1_a_r      <= in_operand_a;
      s1_b_r      <= in_operand_b;
      s1_form_r   <= in_shift_form;
      s1_type_r   <= in_shift_type;
      s1_amt_r    <= in_shift_amount;
      s1_set_r    <= in_set_flags;
      s1_flags_r  <= in_flags_in;
    end
  end

  alubs_shifter u_shifter (
    .operand_b    (s1_b_r),
    .shift_form   (s1_form_r),
    .shift_type   (s1_type_r),
    .shift_amount (s1_amt_r),
    .carry_in     (s1_flags_r[FLAG_C]),
    .res          (shifted)
  );

  alubs_alu u_alu (
    .action       (s1_action_r),
    .operand_a    (s1_a_r),
    .shifted      (shifted),
    .set_flags    (s1_set_r),
    .flags_in     (s1_flags_r),
    .result       (alu_result),
    .write_result (alu_write),
    .flags_out    (alu_flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_result_r <= alu_result;
      out_write_r  <= alu_write;
      out_flags_r  <= alu_flags;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result       = out_result_r;
  assign out_write_result = out_write_r;
  assign out_flags_out    = out_flags_r;

endmodule

`default_nettype wire
